// File: rtl/ppmd_pkg.sv
package ppmd_pkg;

    // Timer handler codes: what the one-shot timeout runs when it expires
    localparam logic [1:0] ARM_NONE = 2'd0;
    localparam logic [1:0] ARM_RISE = 2'd1;
    localparam logic [1:0] ARM_FALL = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_HEALTHY_MIN = 3'd0;
    localparam logic [2:0] REG_HEALTHY_MAX = 3'd1;
    localparam logic [2:0] REG_SYNC_GAP    = 3'd2;
    localparam logic [2:0] REG_MAX_TIMEOUT = 3'd3;
    localparam logic [2:0] REG_CLAMP_MIN   = 3'd4;
    localparam logic [2:0] REG_CLAMP_MAX   = 3'd5;
    localparam logic [2:0] REG_LOW_LIMIT   = 3'd6;
    localparam logic [2:0] REG_HIGH_LIMIT  = 3'd7;

    localparam logic [15:0] SAT16 = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  reg_index;
        logic [15:0] wr_data;
    } t_cfg_wr;

    typedef struct packed {
        logic       pin_level;
        logic [3:0] query_channel;
    } t_in_item;

    typedef struct packed {
        logic [15:0] channel_value;
        logic        is_low;
        logic        is_center;
        logic        is_high;
        logic        frame_valid;
        logic [15:0] period_us;
        logic        frame_committed;
    } t_out_item;

    typedef struct packed {
        logic [15:0] healthy_min_us;
        logic [15:0] healthy_max_us;
        logic [15:0] sync_gap_us;
        logic [15:0] max_timeout_us;
        logic [15:0] clamp_min_us;
        logic [15:0] clamp_max_us;
        logic [15:0] low_limit_us;
        logic [15:0] high_limit_us;
    } t_cfg_regs;

    localparam t_cfg_regs CFG_RESET = '{
        healthy_min_us: 16'd900,
        healthy_max_us: 16'd2100,
        sync_gap_us:    16'd3000,
        max_timeout_us: 16'd5000,
        clamp_min_us:   16'd1000,
        clamp_max_us:   16'd2000,
        low_limit_us:   16'd1250,
        high_limit_us:  16'd1750
    };

    // Clamped channel value and its classification
    typedef struct packed {
        logic [15:0] value;
        logic        is_low;
        logic        is_center;
        logic        is_high;
    } t_query_res;

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        sat_inc16 = (v == SAT16) ? SAT16 : v + 16'd1;
    endfunction

endpackage

// File: rtl/ppmd_if.sv
interface ppmd_cfg_if;
    logic              valid;
    logic              ready;
    ppmd_pkg::t_cfg_wr payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ppmd_in_if;
    logic               valid;
    logic               ready;
    ppmd_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ppmd_out_if;
    logic                valid;
    logic                ready;
    ppmd_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/ppmd_query.sv
module ppmd_query (
    input  logic                 i_in_range,
    input  logic [15:0]          i_raw,
    input  ppmd_pkg::t_cfg_regs  i_cfg,
    output ppmd_pkg::t_query_res o_res
);

    logic [15:0] clamped;

    // Clamp lower bound first, as the limits may be inverted
    always_comb begin
        if (!i_in_range) begin
            clamped = 16'd0;
        end else if (i_raw < i_cfg.clamp_min_us) begin
            clamped = i_cfg.clamp_min_us;
        end else if (i_raw > i_cfg.clamp_max_us) begin
            clamped = i_cfg.clamp_max_us;
        end else begin
            clamped = i_raw;
        end
    end

    assign o_res.value     = clamped;
    assign o_res.is_low    = (clamped < i_cfg.low_limit_us);
    assign o_res.is_center = (i_cfg.low_limit_us < clamped) && (clamped < i_cfg.high_limit_us);
    assign o_res.is_high   = (i_cfg.high_limit_us < clamped);

endmodule

// File: rtl/ppm_frame_decoder.sv
// PPM frame decoder: one receiver pin sample per transaction on i_in, taken
// as one microsecond tick, with a channel index to report.
// i_cfg writes the eight 16-bit limit registers (index 0..7); it is always
// ready and should be used only while no tick is in flight.
// i_in carries pin_level and query_channel. Each accepted tick advances the
// edge timers, measures high pulses, files them into capture slots and
// commits a full healthy frame. o_out returns one result per tick: the
// queried committed channel clamped and classified, the sticky valid flag,
// the last frame period and a commit strobe.
// The result of a tick is in the output register on the edge after acceptance.
// Throughput is one tick per cycle while o_out is not stalled, set by the
// single state update between the input handshake and the output register.
// When the receiver stalls o_out, the output register holds and i_in stops
// accepting until the result is taken; a tick may be accepted on the same
// edge that the held result leaves.
// Reset (i_rst_n low at a rising edge) restores the register defaults,
// clears timers, slot counter, committed slots, valid flag and period, and
// empties the output register.
module ppm_frame_decoder #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ppmd_cfg_if.sink          i_cfg,
    ppmd_in_if.sink           i_in,
    ppmd_out_if.source        o_out
);

    localparam int SLOT_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CNT_W  = $clog2(NUM_CHANNELS + 1);
    localparam logic [CNT_W-1:0] SLOT_COUNT = CNT_W'(NUM_CHANNELS);
    localparam logic [4:0]       QUERY_LIMIT = 5'(NUM_CHANNELS);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    ppmd_pkg::t_cfg_regs r_cfg;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= ppmd_pkg::CFG_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.payload.reg_index)
                ppmd_pkg::REG_HEALTHY_MIN: r_cfg.healthy_min_us <= i_cfg.payload.wr_data;
                ppmd_pkg::REG_HEALTHY_MAX: r_cfg.healthy_max_us <= i_cfg.payload.wr_data;
                ppmd_pkg::REG_SYNC_GAP:    r_cfg.sync_gap_us    <= i_cfg.payload.wr_data;
                ppmd_pkg::REG_MAX_TIMEOUT: r_cfg.max_timeout_us <= i_cfg.payload.wr_data;
                ppmd_pkg::REG_CLAMP_MIN:   r_cfg.clamp_min_us   <= i_cfg.payload.wr_data;
                ppmd_pkg::REG_CLAMP_MAX:   r_cfg.clamp_max_us   <= i_cfg.payload.wr_data;
                ppmd_pkg::REG_LOW_LIMIT:   r_cfg.low_limit_us   <= i_cfg.payload.wr_data;
                ppmd_pkg::REG_HIGH_LIMIT:  r_cfg.high_limit_us  <= i_cfg.payload.wr_data;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Decoder state
    // ---------------------------------------------------------------
    logic [15:0]      r_since_rise, n_since_rise;
    logic [15:0]      r_timeout_cnt, n_timeout_cnt;
    logic [1:0]       r_pending, n_pending;
    logic             r_last_pin;
    logic [CNT_W-1:0] r_slot_idx, n_slot_idx;
    logic             r_healthy, n_healthy;
    logic             r_valid_flag, n_valid_flag;
    logic [15:0]      r_period, n_period;
    logic [15:0]      r_since_commit, n_since_commit;
    logic [15:0]      r_capture [NUM_CHANNELS];
    logic [15:0]      r_committed [NUM_CHANNELS];

    logic             r_out_valid;
    ppmd_pkg::t_out_item r_out;

    logic             in_acc;
    logic             pin;
    logic             armed;
    logic             rise_edge;
    logic             fall_edge;
    logic             expired;
    logic             do_rise;
    logic             do_fall;
    logic [15:0]      sr_inc;
    logic [15:0]      tc_inc;
    logic             pulse_kept;
    logic             new_frame;
    logic             cap_wr;
    logic             commit;
    logic             q_in_range;
    logic [15:0]      q_raw;
    ppmd_pkg::t_query_res q_res;

    // A new tick can enter whenever the output register is empty or draining
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;
    assign pin        = i_in.payload.pin_level;

    assign sr_inc    = ppmd_pkg::sat_inc16(r_since_rise);
    assign armed     = (r_pending == ppmd_pkg::ARM_RISE) || (r_pending == ppmd_pkg::ARM_FALL);
    assign rise_edge = pin && !r_last_pin;
    assign fall_edge = !pin && r_last_pin;

    assign tc_inc  = armed ? ppmd_pkg::sat_inc16(r_timeout_cnt) : r_timeout_cnt;
    assign expired = armed && (tc_inc >= r_cfg.max_timeout_us);

    // An edge wins over an expiring timeout; the timeout runs the armed handler
    assign do_rise = rise_edge
                  || (!rise_edge && !fall_edge && expired && r_pending == ppmd_pkg::ARM_RISE);
    assign do_fall = fall_edge
                  || (!rise_edge && !fall_edge && expired && r_pending == ppmd_pkg::ARM_FALL);

    // Pulse filing: the measured pulse is the advanced rise counter
    assign pulse_kept = sr_inc < r_cfg.max_timeout_us;
    assign new_frame  = (sr_inc > r_cfg.sync_gap_us) || (r_slot_idx >= SLOT_COUNT);
    assign cap_wr     = do_fall && pulse_kept && !new_frame;

    always_comb begin
        n_since_rise   = sr_inc;
        n_since_commit = ppmd_pkg::sat_inc16(r_since_commit);
        n_timeout_cnt  = tc_inc;
        n_pending      = r_pending;
        n_slot_idx     = r_slot_idx;
        n_healthy      = r_healthy;
        n_valid_flag   = r_valid_flag;
        n_period       = r_period;
        commit         = 1'b0;
        if (do_rise) begin
            n_since_rise  = 16'd0;
            n_pending     = ppmd_pkg::ARM_FALL;
            n_timeout_cnt = 16'd0;
        end
        if (do_fall) begin
            if (pulse_kept) begin
                if (new_frame) begin
                    n_slot_idx = '0;
                    n_healthy  = 1'b1;
                end else begin
                    if (sr_inc < r_cfg.healthy_min_us || sr_inc > r_cfg.healthy_max_us) begin
                        n_healthy = 1'b0;
                    end
                    n_slot_idx = r_slot_idx + CNT_W'(1);
                    if (n_slot_idx == SLOT_COUNT && n_healthy) begin
                        commit         = 1'b1;
                        n_valid_flag   = 1'b1;
                        n_period       = n_since_commit;
                        n_since_commit = 16'd0;
                    end
                end
            end
            n_pending     = ppmd_pkg::ARM_RISE;
            n_timeout_cnt = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_since_rise   <= 16'd0;
            r_since_commit <= 16'd0;
            r_timeout_cnt  <= 16'd0;
            r_pending      <= ppmd_pkg::ARM_NONE;
            r_last_pin     <= 1'b0;
            r_slot_idx     <= '0;
            r_healthy      <= 1'b1;
            r_valid_flag   <= 1'b0;
            r_period       <= 16'd0;
        end else if (in_acc) begin
            r_since_rise   <= n_since_rise;
            r_since_commit <= n_since_commit;
            r_timeout_cnt  <= n_timeout_cnt;
            r_pending      <= n_pending;
            r_last_pin     <= pin;
            r_slot_idx     <= n_slot_idx;
            r_healthy      <= n_healthy;
            r_valid_flag   <= n_valid_flag;
            r_period       <= n_period;
        end
    end

    // Capture slots hold no reset: a commit needs every slot filled first
    always_ff @(posedge i_clk) begin
        if (in_acc && cap_wr) begin
            r_capture[r_slot_idx[SLOT_W-1:0]] <= sr_inc;
        end
    end

    // Commit copies the frame; the last slot comes straight from this pulse
    for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_commit
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_committed[g] <= 16'd0;
            end else if (in_acc && commit) begin
                r_committed[g] <= (g == NUM_CHANNELS - 1) ? sr_inc : r_capture[g];
            end
        end
    end

    // ---------------------------------------------------------------
    // Query: report the committed value as it stands after this tick
    // ---------------------------------------------------------------
    assign q_in_range = {1'b0, i_in.payload.query_channel} < QUERY_LIMIT;

    always_comb begin
        if (!q_in_range) begin
            q_raw = 16'd0;
        end else if (commit && {1'b0, i_in.payload.query_channel} == QUERY_LIMIT - 5'd1) begin
            q_raw = sr_inc;
        end else if (commit) begin
            q_raw = r_capture[i_in.payload.query_channel[SLOT_W-1:0]];
        end else begin
            q_raw = r_committed[i_in.payload.query_channel[SLOT_W-1:0]];
        end
    end

    ppmd_query u_query (
        .i_in_range (q_in_range),
        .i_raw      (q_raw),
        .i_cfg      (r_cfg),
        .o_res      (q_res)
    );

    // ---------------------------------------------------------------
    // Output register: hold while the receiver stalls
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out.channel_value   <= q_res.value;
            r_out.is_low          <= q_res.is_low;
            r_out.is_center       <= q_res.is_center;
            r_out.is_high         <= q_res.is_high;
            r_out.frame_valid     <= n_valid_flag;
            r_out.period_us       <= n_period;
            r_out.frame_committed <= commit;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_commit_sets_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.payload.frame_committed) |-> o_out.payload.frame_valid)
        else $error("committed frame reported without valid flag");

    a_slot_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot_idx <= SLOT_COUNT)
        else $error("slot index beyond channel count");

    a_commit_fills : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && commit) |=> (r_slot_idx == SLOT_COUNT && r_since_commit == 16'd0))
        else $error("commit without a full frame");

    a_tick_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_out_valid)
        else $error("accepted tick produced no result");

endmodule
